// ===== src/mlfs_pkg.sv =====
`timescale 1ns / 1ps

package mlfs_pkg;

	localparam int TASK_COUNT_DEF = 5;
	localparam int LEVEL_COUNT = 3;

	localparam int FUNC_W = 2;
	localparam int IDX_W = 3;
	localparam int LVL_W = 2;
	localparam int PRI_W = 2;
	localparam int TIME_W = 12;
	localparam int TICK_W = 16;

	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd2;

	localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
	localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
	localparam logic [LVL_W-1:0] LVL_LAST = 2'd2;

	localparam logic [TIME_W-1:0] QUANTUM_L0 = 12'd5;
	localparam logic [TIME_W-1:0] QUANTUM_L1 = 12'd10;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  task_index;
		logic [LVL_W-1:0]  level;
		logic [PRI_W-1:0]  priority_value;
		logic [TIME_W-1:0] burst_time;
		logic [TICK_W-1:0] arrival_tick;
	} req_t;

	typedef struct packed {
		logic              dispatched;
		logic [IDX_W-1:0]  task_run;
		logic [LVL_W-1:0]  run_level;
		logic [TIME_W-1:0] slice_len;
		logic [TICK_W-1:0] slice_end;
	} rsp_t;

endpackage

// ===== src/mlfs_ram.sv =====
`timescale 1ns / 1ps

module mlfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/mlfs_pick.sv =====
`timescale 1ns / 1ps

module mlfs_pick import mlfs_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          step,
	input  logic                          cand_present,
	input  logic [PRI_W-1:0]              cand_pri,
	input  logic [$clog2(TASK_COUNT)-1:0] cand_idx,
	output logic                          found,
	output logic [$clog2(TASK_COUNT)-1:0] best_idx
);

	localparam int IW = $clog2(TASK_COUNT);

	logic             found_q;
	logic [IW-1:0]    best_idx_q;
	logic [PRI_W-1:0] best_pri_q;
	logic             better;

	// strict less-than keeps the lowest index on ties, since the scan ascends
	assign better = cand_present && (!found_q || (cand_pri < best_pri_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_idx_q <= '0;
			best_pri_q <= '0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (step && better) begin
			found_q <= 1'b1;
			best_idx_q <= cand_idx;
			best_pri_q <= cand_pri;
		end
	end

	assign found = found_q;
	assign best_idx = best_idx_q;

endmodule

// ===== src/multilevel_feedback_scheduler.sv =====
`timescale 1ns / 1ps

// Channel  Signals                     Dir  Payload
// req      req_valid, req_ready, req   in   req_t: func, task, level, priority, burst, arrival
// rsp      rsp_valid, rsp_ready, rsp   out  rsp_t: dispatched, task, level, slice, end tick
//
// One item is worked at a time; req_ready is high only while the sequencer is idle.
// Load and unused codes go straight to the push step. A tick or a dispatch scans the
// tasks one per cycle, and each task's RAM read is registered before it is checked.
// A dispatch scans level 0 first and moves down a level while the compare unit finds none.
// Reset clears tick count, presence flags and remaining times; priority and arrival
// RAMs hold garbage until loaded. A stalled rsp holds the sequencer in its push step.

module multilevel_feedback_scheduler import mlfs_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = $clog2(TASK_COUNT);
	localparam int PRI_AW = IW + LVL_W;
	localparam int PRI_DEPTH = 2 ** PRI_AW;
	localparam logic [IW-1:0] LAST_IDX = IW'(TASK_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_TICK_END,
		ST_DISP,
		ST_DISP_END,
		ST_DISP_CHK,
		ST_PUSH
	} state_t;

	state_t state_q;

	logic [TICK_W-1:0]      tick_count_q;
	logic [LEVEL_COUNT-1:0] present_q [TASK_COUNT];
	logic [TIME_W-1:0]      time_left_q [TASK_COUNT];

	logic [IW-1:0]    scan_q;
	logic [LVL_W-1:0] level_q;
	logic             disp_q;
	logic             issue_s1;
	logic [IW-1:0]    idx_s1;

	rsp_t res_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept;
	logic ld_ok;
	logic [IW-1:0] ld_idx;

	logic                pri_we;
	logic [PRI_AW-1:0]   pri_waddr;
	logic [PRI_AW-1:0]   pri_raddr;
	logic [PRI_W-1:0]    pri_rdata;
	logic                arr_we;
	logic [TICK_W-1:0]   arr_rdata;

	logic          pick_clear;
	logic          pick_step;
	logic          pick_found;
	logic [IW-1:0] pick_idx;

	logic [TIME_W-1:0] rem;
	logic [TIME_W-1:0] quantum;
	logic [TIME_W-1:0] slice;
	logic [TICK_W-1:0] slice_end;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;

	// loads beyond the task set or at the unused level write nothing
	assign ld_idx = IW'(req.task_index);
	assign ld_ok = ({29'b0, req.task_index} < 32'(TASK_COUNT))
		&& ({30'b0, req.level} < 32'(LEVEL_COUNT));

	assign pri_we = accept && (req.func == FUNC_LOAD) && ld_ok;
	assign arr_we = pri_we && (req.level == LVL_TOP);
	assign pri_waddr = {req.level, ld_idx};
	assign pri_raddr = {level_q, scan_q};

	mlfs_ram #(
		.WIDTH(PRI_W),
		.DEPTH(PRI_DEPTH)
	) u_pri_ram (
		.clk  (clk),
		.we   (pri_we),
		.waddr(pri_waddr),
		.wdata(req.priority_value),
		.raddr(pri_raddr),
		.rdata(pri_rdata)
	);

	mlfs_ram #(
		.WIDTH(TICK_W),
		.DEPTH(TASK_COUNT)
	) u_arr_ram (
		.clk  (clk),
		.we   (arr_we),
		.waddr(ld_idx),
		.wdata(req.arrival_tick),
		.raddr(scan_q),
		.rdata(arr_rdata)
	);

	// restart the search at the start of a dispatch and before each lower level
	assign pick_clear = (accept && (req.func == FUNC_DISPATCH))
		|| ((state_q == ST_DISP_CHK) && !pick_found);
	assign pick_step = issue_s1 && disp_q;

	mlfs_pick #(
		.TASK_COUNT(TASK_COUNT)
	) u_pick (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (pick_clear),
		.step        (pick_step),
		.cand_present(present_q[idx_s1][level_q]),
		.cand_pri    (pri_rdata),
		.cand_idx    (idx_s1),
		.found       (pick_found),
		.best_idx    (pick_idx)
	);

	// slice for the winner: level quantum capped by remaining time
	always_comb begin
		rem = time_left_q[pick_idx];
		case (level_q)
			LVL_TOP: quantum = QUANTUM_L0;
			LVL_MID: quantum = QUANTUM_L1;
			default: quantum = rem;
		endcase
		slice = (rem > quantum) ? quantum : rem;
		slice_end = tick_count_q + {{(TICK_W-TIME_W){1'b0}}, slice};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_count_q <= '0;
			for (int i = 0; i < TASK_COUNT; i++) begin
				present_q[i] <= '0;
				time_left_q[i] <= '0;
			end
			scan_q <= '0;
			level_q <= '0;
			disp_q <= 1'b0;
			issue_s1 <= 1'b0;
			idx_s1 <= '0;
			res_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the output once the consumer takes the transfer
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// tick scan, second half: admit on arrival match, then remove when empty
			if (issue_s1 && !disp_q) begin
				if (time_left_q[idx_s1] == '0) begin
					present_q[idx_s1] <= '0;
				end else if (arr_rdata == tick_count_q) begin
					present_q[idx_s1][0] <= 1'b1;
				end
			end

			issue_s1 <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= '0;
						scan_q <= '0;
						level_q <= LVL_TOP;
						case (req.func)
							FUNC_LOAD: begin
								if (ld_ok && (req.level == LVL_TOP)) begin
									time_left_q[ld_idx] <= req.burst_time;
									present_q[ld_idx] <= '0;
								end
								state_q <= ST_PUSH;
							end
							FUNC_TICK: begin
								tick_count_q <= tick_count_q + 1'b1;
								disp_q <= 1'b0;
								state_q <= ST_TICK;
							end
							FUNC_DISPATCH: begin
								disp_q <= 1'b1;
								state_q <= ST_DISP;
							end
							default: begin
								state_q <= ST_PUSH;
							end
						endcase
					end
				end
				ST_TICK, ST_DISP: begin
					// issue one task per cycle; its RAM data is checked next cycle
					issue_s1 <= 1'b1;
					idx_s1 <= scan_q;
					if (scan_q == LAST_IDX) begin
						scan_q <= '0;
						state_q <= (state_q == ST_TICK) ? ST_TICK_END : ST_DISP_END;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_TICK_END: begin
					state_q <= ST_PUSH;
				end
				ST_DISP_END: begin
					state_q <= ST_DISP_CHK;
				end
				ST_DISP_CHK: begin
					if (pick_found) begin
						time_left_q[pick_idx] <= rem - slice;
						present_q[pick_idx][level_q] <= 1'b0;
						if (level_q != LVL_LAST) begin
							present_q[pick_idx][2'(level_q + 1'b1)] <= 1'b1;
						end
						res_q.dispatched <= 1'b1;
						res_q.task_run <= IDX_W'(pick_idx);
						res_q.run_level <= level_q;
						res_q.slice_len <= slice;
						res_q.slice_end <= slice_end;
						state_q <= ST_PUSH;
					end else if (level_q == LVL_LAST) begin
						state_q <= ST_PUSH;
					end else begin
						level_q <= level_q + 1'b1;
						state_q <= ST_DISP;
					end
				end
				ST_PUSH: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q <= res_q;
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Block test for the three-level feedback scheduler.
// Load, tick and dispatch items are sent one at a time over the request channel.
// An in-bench scheduler tracks tick count, per-level presence, priorities,
// remaining times and arrival ticks, and predicts the result of each accepted item.
// Every response transfer is checked field by field against the oldest prediction.
// The run covers a directed opening and random traffic under four idling patterns.
module tb_top;
	import mlfs_pkg::*;

	localparam int TASKS = TASK_COUNT_DEF;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	// Codes the block accepts but must ignore
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [LVL_W-1:0] LVL_NONE = 2'd3;

	// Slice length per level; the last level runs to completion
	localparam logic [TIME_W-1:0] QUANT_TOP = 12'd5;
	localparam logic [TIME_W-1:0] QUANT_MID = 12'd10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Scheduler state as the bench sees it
	logic [TICK_W-1:0] sim_tick = '0;
	logic [LEVEL_COUNT-1:0] in_level [TASKS] = '{default: '0};
	logic [PRI_W-1:0] pri_tab [LEVEL_COUNT][TASKS] = '{default: '{default: '0}};
	logic [TIME_W-1:0] burst_left [TASKS] = '{default: '0};
	logic [TICK_W-1:0] arrive_at [TASKS] = '{default: '0};

	// Predicted grants, oldest first
	rsp_t grant_due [$];

	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;

	multilevel_feedback_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stall the response channel at the current rate
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Apply one item to the bench state and return the result it must produce
	function automatic rsp_t predict_grant(input req_t r);
		rsp_t g;
		int best;
		int best_pri;
		logic [TIME_W-1:0] left;
		logic [TIME_W-1:0] slice;
		g = '0;
		case (r.func)
			FUNC_LOAD: begin
				// Out-of-range slots and level 3 write nothing
				if (r.task_index < TASKS && r.level < LEVEL_COUNT) begin
					pri_tab[r.level][r.task_index] = r.priority_value;
					if (r.level == LVL_TOP) begin
						burst_left[r.task_index] = r.burst_time;
						arrive_at[r.task_index] = r.arrival_tick;
						in_level[r.task_index] = '0;
					end
				end
			end
			FUNC_TICK: begin
				sim_tick = sim_tick + 1'b1;
				// Admit first, then drop finished tasks: removal wins on the same tick
				for (int t = 0; t < TASKS; t++) begin
					if (arrive_at[t] == sim_tick)
						in_level[t][LVL_TOP] = 1'b1;
					if (burst_left[t] == '0)
						in_level[t] = '0;
				end
			end
			FUNC_DISPATCH: begin
				// Serve the first nonempty level; lowest priority value, lowest index on ties
				for (int l = 0; l < LEVEL_COUNT && !g.dispatched; l++) begin
					best = -1;
					best_pri = 4;
					for (int t = 0; t < TASKS; t++) begin
						if (in_level[t][l] && pri_tab[l][t] < best_pri) begin
							best = t;
							best_pri = pri_tab[l][t];
						end
					end
					if (best >= 0) begin
						left = burst_left[best];
						slice = left;
						if (l == LVL_TOP && left > QUANT_TOP)
							slice = QUANT_TOP;
						else if (l == LVL_MID && left > QUANT_MID)
							slice = QUANT_MID;
						burst_left[best] = left - slice;
						// Demote one level, or retire from the last level
						in_level[best][l] = 1'b0;
						if (l + 1 < LEVEL_COUNT)
							in_level[best][l + 1] = 1'b1;
						g.dispatched = 1'b1;
						g.task_run = IDX_W'(best);
						g.run_level = LVL_W'(l);
						g.slice_len = slice;
						g.slice_end = sim_tick + TICK_W'(slice);
					end
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	function automatic req_t make_req(input logic [FUNC_W-1:0] f, input int idx,
			input int lvl, input int pri, input int burst, input int arr);
		req_t r;
		r.func = f;
		r.task_index = IDX_W'(idx);
		r.level = LVL_W'(lvl);
		r.priority_value = PRI_W'(pri);
		r.burst_time = TIME_W'(burst);
		r.arrival_tick = TICK_W'(arr);
		return r;
	endfunction

	// Present one item, hold it until the transfer, then log its prediction.
	// Valid is lowered only on an idle gap, so back-to-back items keep it high.
	task automatic send_req(input req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		grant_due.push_back(predict_grant(item));
	endtask

	// Hold off the sender until every predicted grant has come back
	task automatic wait_results_done();
		req_valid <= 1'b0;
		do @(posedge clk); while (grant_due.size() != 0);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Check each response transfer against the oldest prediction
	always @(posedge clk) begin : check_grants
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			if (grant_due.size() == 0) begin
				$error("unexpected result: dispatched %0d task %0d level %0d slice %0d end %0d",
					rsp.dispatched, rsp.task_run, rsp.run_level, rsp.slice_len, rsp.slice_end);
				mismatches++;
			end else begin
				want = grant_due.pop_front();
				check_field("dispatched", 16'(want.dispatched), 16'(rsp.dispatched));
				check_field("task_run", 16'(want.task_run), 16'(rsp.task_run));
				check_field("run_level", 16'(want.run_level), 16'(rsp.run_level));
				check_field("slice_len", 16'(want.slice_len), 16'(rsp.slice_len));
				check_field("slice_end", want.slice_end, rsp.slice_end);
			end
		end
	end

	// Fill every priority, burst and arrival entry, then walk the special cases
	task automatic test_directed();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		// Level 0: longest burst, exact quantum, zero burst, plain, latest arrival
		send_req(make_req(FUNC_LOAD, 0, LVL_TOP, 3, 4095, 1));
		send_req(make_req(FUNC_LOAD, 1, LVL_TOP, 0, 5, 1));
		send_req(make_req(FUNC_LOAD, 2, LVL_TOP, 1, 0, 1));
		send_req(make_req(FUNC_LOAD, 3, LVL_TOP, 0, 12, 2));
		send_req(make_req(FUNC_LOAD, 4, LVL_TOP, 2, 1, 16'hFFFF));
		for (int t = 0; t < TASKS; t++) begin
			send_req(make_req(FUNC_LOAD, t, LVL_MID, (t == 0) ? 1 : 0, 0, 0));
			send_req(make_req(FUNC_LOAD, t, LVL_LAST, 3 - (t % 4), 0, 0));
		end
		// Ignored loads and the unused code; a wrong write here would clear task 0
		send_req(make_req(FUNC_LOAD, 0, LVL_NONE, 3, 0, 0));
		send_req(make_req(FUNC_LOAD, 5, LVL_TOP, 0, 0, 0));
		send_req(make_req(FUNC_LOAD, 7, LVL_LAST, 3, 4095, 16'hFFFF));
		send_req(make_req(FUNC_UNUSED, 7, LVL_NONE, 3, 4095, 16'hFFFF));
		// Empty dispatch, then admit tasks 0 and 1 while task 2 is admitted and dropped
		send_req(make_req(FUNC_DISPATCH, 0, 0, 0, 0, 0));
		send_req(make_req(FUNC_TICK, 0, 0, 0, 0, 0));
		// Task 1 spends its whole time at level 0 and then gets a zero slice at level 1
		repeat (4) send_req(make_req(FUNC_DISPATCH, 0, 0, 0, 0, 0));
		send_req(make_req(FUNC_TICK, 0, 0, 0, 0, 0));
		send_req(make_req(FUNC_DISPATCH, 0, 0, 0, 0, 0));
		wait_results_done();
	endtask

	// Random traffic: mostly admissions near the current tick, ticks and dispatches,
	// with some fully random items including ignored codes and slots
	task automatic test_random(input int n_items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int done_cnt;
		int unsigned pick;
		int slot;
		int burst;
		req_t item;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		done_cnt = 0;
		while (done_cnt < n_items) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				item.func = FUNC_W'($urandom_range(3));
				item.task_index = IDX_W'($urandom_range(7));
				item.level = LVL_W'($urandom_range(3));
				item.priority_value = PRI_W'($urandom_range(3));
				item.burst_time = TIME_W'($urandom_range(4095));
				item.arrival_tick = TICK_W'($urandom_range(65535));
				send_req(item);
				if (item.func != FUNC_UNUSED &&
						!(item.func == FUNC_LOAD &&
						(item.task_index >= TASKS || item.level >= LEVEL_COUNT)))
					done_cnt++;
			end else if (pick < 20) begin
				// Arrive within a few ticks; bursts mostly short, now and then long
				slot = $urandom_range(TASKS - 1);
				burst = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(30);
				send_req(make_req(FUNC_LOAD, slot, LVL_TOP, $urandom_range(3), burst,
					sim_tick + $urandom_range(1, 4)));
				done_cnt++;
				if ($urandom_range(1)) begin
					send_req(make_req(FUNC_LOAD, slot, $urandom_range(1, 2),
						$urandom_range(3), $urandom_range(4095), $urandom_range(65535)));
					done_cnt++;
				end
			end else if (pick < 55) begin
				send_req(make_req(FUNC_TICK, 0, 0, 0, 0, 0));
				done_cnt++;
			end else begin
				send_req(make_req(FUNC_DISPATCH, 0, 0, 0, 0, 0));
				done_cnt++;
			end
		end
		wait_results_done();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250, 0, 0);
		test_random(250, 85, 0);
		test_random(250, 0, 85);
		test_random(250, 10, 10);

		// Let any stray result surface before the verdict
		wait_results_done();
		repeat (3 * TASKS + 12) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
